// ----- rtl/core/kvlt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvlt_pkg
// shared types and constants of the key/value line tokenizer
// ----------------------------------------------------------------------------
package kvlt_pkg;

    // default sizes handed to the top level
    localparam int STACK_DEPTH_DEF = 16;
    localparam int LINE_MAX_DEF    = 1024;

    // bundles held between front and back
    localparam int QUEUE_DEPTH = 4;

    // characters of interest
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        PH_INDENT,
        PH_KEY,
        PH_WS,
        PH_VALUE,
        PH_OK,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        EV_INDENT   = 3'd0,
        EV_KEY      = 3'd1,
        EV_VALUE    = 3'd2,
        EV_LINE_OK  = 3'd3,
        EV_LINE_ERR = 3'd4
    } ev_kind_t;

    // all results caused by one input item
    typedef struct packed {
        logic        ind_v;
        logic [7:0]  old_indent;
        logic        tok_v;
        logic        tok_value;
        logic [9:0]  tok_start;
        logic [10:0] tok_len;
        logic        st_v;
        logic        st_err;
        logic [7:0]  new_indent;
    } bundle_t;

    // one result item
    typedef struct packed {
        ev_kind_t    kind;
        logic [9:0]  token_start;
        logic [10:0] token_length;
        logic [7:0]  new_indent;
        logic [7:0]  old_indent;
        logic        final_result;
    } result_t;

endpackage

// ----- rtl/core/kvlt_front.sv -----
// ----------------------------------------------------------------------------
// kvlt_front
// per-character line scanner and indentation stack, emits at most one bundle per item
// ----------------------------------------------------------------------------
module kvlt_front #(
    parameter int STACK_DEPTH = kvlt_pkg::STACK_DEPTH_DEF,
    parameter int LINE_MAX    = kvlt_pkg::LINE_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        in_char,
    input  logic              in_last,
    output logic              push,
    output kvlt_pkg::bundle_t push_data
);
    import kvlt_pkg::*;

    localparam int POS_W = $clog2(LINE_MAX + 1);
    localparam int LW    = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_MAX);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       space_reg, space_next;
    logic [POS_W-1:0] tbeg_reg, tbeg_next;
    logic [POS_W-1:0] lns_reg, lns_next;
    logic             vseen_reg, vseen_next;
    logic [LW-1:0]    level_reg, level_next;
    logic [7:0]       top_reg, under_reg, rd_reg;
    logic [7:0]       stack_mem [STACK_DEPTH];

    logic accept;
    assign accept = in_valid && in_ready;

    // indentation check against cached top two levels
    logic chk_push, chk_pop, chk_fail, chk_event;

    always_comb begin
        chk_push  = 1'b0;
        chk_pop   = 1'b0;
        chk_fail  = 1'b0;
        chk_event = 1'b0;
        if (level_reg == '0) begin
            chk_push = 1'b1;
        end else if (top_reg == space_reg) begin
            chk_push = 1'b0;
        end else if (space_reg > top_reg) begin
            if (level_reg >= LW'(STACK_DEPTH)) begin
                chk_fail = 1'b1;
            end else begin
                chk_push  = 1'b1;
                chk_event = 1'b1;
            end
        end else begin
            chk_pop = 1'b1;
            if (level_reg > LW'(1) && under_reg > space_reg) begin
                chk_fail = 1'b1;
            end else begin
                chk_event = 1'b1;
            end
        end
    end

    function automatic logic is_open(input phase_t ph);
        return (ph != PH_OK) && (ph != PH_ERR);
    endfunction

    function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] tb,
                                              input logic [POS_W-1:0] ln);
        return (ln > tb) ? ln - tb : '0;
    endfunction

    // walk of one character through the line phases
    phase_t           ph;
    logic [7:0]       sc;
    logic [POS_W-1:0] tb, ln, tok_s, tok_l, pos_inc;
    logic             vs, go, do_close, do_check, key_v, val_v, is_sp, is_term;

    assign pos_inc = pos_reg + POS_W'(1);

    always_comb begin
        ph       = phase_reg;
        sc       = space_reg;
        tb       = tbeg_reg;
        ln       = lns_reg;
        vs       = vseen_reg;
        go       = 1'b0;
        do_close = 1'b0;
        do_check = 1'b0;
        key_v    = 1'b0;
        val_v    = 1'b0;
        tok_s    = '0;
        tok_l    = '0;
        is_sp    = (in_char == CH_SPACE);
        is_term  = (in_char == CH_HASH) || (in_char == CH_CR) || (in_char == CH_LF);
        if (is_open(phase_reg)) begin
            if (pos_reg >= POS_LIMIT) begin
                ph = PH_ERR;
            end else if (is_term) begin
                do_close = 1'b1;
            end else begin
                go = 1'b1;
                if (ph == PH_INDENT) begin
                    if (is_sp) begin
                        if (sc != 8'hFF) sc = sc + 8'd1;
                        go = 1'b0;
                    end else begin
                        do_check = 1'b1;
                        if (chk_fail) begin
                            ph = PH_ERR;
                            go = 1'b0;
                        end else begin
                            tb = pos_reg;
                            ln = '0;
                            ph = PH_KEY;
                        end
                    end
                end
                if (go && ph == PH_KEY) begin
                    if (in_char == CH_COLON) begin
                        key_v = 1'b1;
                        tok_s = tb;
                        tok_l = span(tb, ln);
                        ph    = PH_WS;
                    end else if (!is_sp) begin
                        ln = pos_inc;
                    end
                    go = 1'b0;
                end
                if (go && ph == PH_WS) begin
                    if (is_sp) go = 1'b0;
                    else ph = PH_VALUE;
                end
                if (go && ph == PH_VALUE) begin
                    if (!vs) begin
                        vs = 1'b1;
                        tb = pos_reg;
                        ln = '0;
                    end
                    if (!is_sp) ln = pos_inc;
                end
                if (in_last && is_open(ph)) do_close = 1'b1;
            end
        end
        if (do_close) begin
            if (ph == PH_VALUE) begin
                val_v = 1'b1;
                tok_s = tb;
                tok_l = span(tb, ln);
                ph    = PH_OK;
            end else if (ph == PH_INDENT || ph == PH_WS) begin
                ph = PH_OK;
            end else if (ph == PH_KEY) begin
                ph = PH_ERR;
            end
        end
    end

    // next state
    logic do_push, do_pop;
    assign do_push = accept && do_check && chk_push;
    assign do_pop  = accept && do_check && chk_pop;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        space_next = space_reg;
        tbeg_next  = tbeg_reg;
        lns_next   = lns_reg;
        vseen_next = vseen_reg;
        if (accept) begin
            if (in_last) begin
                phase_next = PH_INDENT;
                pos_next   = '0;
                space_next = '0;
                tbeg_next  = '0;
                lns_next   = '0;
                vseen_next = 1'b0;
            end else begin
                phase_next = ph;
                pos_next   = (pos_reg < POS_LIMIT) ? pos_inc : pos_reg;
                space_next = sc;
                tbeg_next  = tb;
                lns_next   = ln;
                vseen_next = vs;
            end
        end
    end

    always_comb begin
        level_next = level_reg;
        if (do_push) level_next = level_reg + LW'(1);
        else if (do_pop) level_next = level_reg - LW'(1);
    end

    // bundle outputs
    logic [POS_W+10:0] tok_s_w, tok_l_w;
    assign tok_s_w = (POS_W+11)'(tok_s);
    assign tok_l_w = (POS_W+11)'(tok_l);

    always_comb begin
        push_data.ind_v      = do_check && chk_event;
        push_data.old_indent = top_reg;
        push_data.tok_v      = key_v || val_v;
        push_data.tok_value  = val_v;
        push_data.tok_start  = tok_s_w[9:0];
        push_data.tok_len    = tok_l_w[10:0];
        push_data.st_v       = in_last;
        push_data.st_err     = (ph != PH_OK);
        push_data.new_indent = sc;
        push = accept && (push_data.ind_v || push_data.tok_v || push_data.st_v);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_INDENT;
            pos_reg   <= '0;
            space_reg <= '0;
            tbeg_reg  <= '0;
            lns_reg   <= '0;
            vseen_reg <= 1'b0;
            level_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            space_reg <= space_next;
            tbeg_reg  <= tbeg_next;
            lns_reg   <= lns_next;
            vseen_reg <= vseen_next;
            level_reg <= level_next;
        end
    end

    // stack: full copy in memory, top two levels cached, third prefetched
    logic [LW-1:0] rd_addr_full;
    assign rd_addr_full = level_next - LW'(3);

    always_ff @(posedge aclk) begin
        if (do_push) begin
            stack_mem[level_reg[AW-1:0]] <= space_reg;
            top_reg   <= space_reg;
            under_reg <= top_reg;
        end else if (do_pop) begin
            top_reg   <= under_reg;
            under_reg <= rd_reg;
        end
        if (level_next >= LW'(3)) rd_reg <= stack_mem[rd_addr_full[AW-1:0]];
    end

endmodule

// ----- rtl/core/kvlt_queue.sv -----
// ----------------------------------------------------------------------------
// kvlt_queue
// small bundle queue between front and back
// ----------------------------------------------------------------------------
module kvlt_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  kvlt_pkg::bundle_t push_data,
    input  logic              pop,
    output kvlt_pkg::bundle_t head,
    output logic              full,
    output logic              empty
);
    import kvlt_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    bundle_t       slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop) rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop) count_reg <= count_reg + (PW+1)'(1);
            else if (pop && !push) count_reg <= count_reg - (PW+1)'(1);
        end
    end

endmodule

// ----- rtl/core/kvlt_back.sv -----
// ----------------------------------------------------------------------------
// kvlt_back
// splits each bundle into registered result items, one per unstalled cycle
// ----------------------------------------------------------------------------
module kvlt_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  kvlt_pkg::bundle_t head,
    input  logic              q_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output kvlt_pkg::result_t out_data
);
    import kvlt_pkg::*;

    logic [2:0] done_reg, done_next;
    logic [2:0] remaining, sel, left;
    logic       out_valid_reg, out_valid_next, load, is_final;
    result_t    out_reg, out_next;

    assign remaining = {head.st_v, head.tok_v, head.ind_v} & ~done_reg;
    assign load      = (!out_valid_reg || out_ready) && !q_empty;

    // order: indent, token, line status
    always_comb begin
        priority if (remaining[0]) sel = 3'b001;
        else if (remaining[1]) sel = 3'b010;
        else sel = 3'b100;
    end

    assign left     = remaining & ~sel;
    assign is_final = (left == '0);
    assign pop      = load && is_final;

    always_comb begin
        out_next              = out_reg;
        out_next.new_indent   = head.new_indent;
        out_next.final_result = is_final;
        out_next.token_start  = '0;
        out_next.token_length = '0;
        out_next.old_indent   = '0;
        unique case (sel)
            3'b001: begin
                out_next.kind       = EV_INDENT;
                out_next.old_indent = head.old_indent;
            end
            3'b010: begin
                out_next.kind         = head.tok_value ? EV_VALUE : EV_KEY;
                out_next.token_start  = head.tok_start;
                out_next.token_length = head.tok_len;
            end
            default: begin
                out_next.kind = head.st_err ? EV_LINE_ERR : EV_LINE_OK;
            end
        endcase
    end

    always_comb begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            done_next      = is_final ? 3'b000 : (done_reg | sel);
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/core/key_value_line_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// key_value_line_tokenizer_top
// streaming tokenizer for indented "key: value" lines, one character per item
// ----------------------------------------------------------------------------
// Characters of a line enter one per item, with s_tlast on the final byte of
// the line buffer. The front scanner takes one item every clock cycle as long
// as its bundle queue (four entries) has room; it never waits on the output
// side directly. Each item that causes results leaves one bundle of one to
// three result items (indent change, key or value, line status) in the
// queue. The back end sends exactly one result item per cycle through an
// output register while the receiver is ready, so the output stream sets
// the sustained rate: a line of n characters needs n input items and one
// output item per result (at most an indent change, key, value, status). The
// indentation stack is kept in a memory of STACK_DEPTH entries, undefined
// after reset, with the top two levels cached in registers and the third
// prefetched through the memory's registered read port, so back-to-back
// indent checks on consecutive one-character lines run at full rate. No
// clearing pass is needed after reset. A line that is still open when a byte
// arrives at offset LINE_MAX or beyond reports a line error on its last byte.
// ----------------------------------------------------------------------------
module key_value_line_tokenizer_top #(
    parameter int STACK_DEPTH = kvlt_pkg::STACK_DEPTH_DEF,  // levels held, 2 to 256
    parameter int LINE_MAX    = kvlt_pkg::LINE_MAX_DEF      // longest line, 16 to 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // character items in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // last_char
    // result items out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] event_kind, [12:3] token_start,
                                   // [23:13] token_length, [31:24] new_indent,
                                   // [39:32] old_indent
    output logic        m_tlast    // final_result
);
    import kvlt_pkg::*;

    logic    q_push, q_pop, q_full, q_empty;
    bundle_t q_in, q_head;
    result_t res;

    // front only waits on queue space
    assign s_tready = !q_full;

    kvlt_front #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_MAX    (LINE_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .push      (q_push),
        .push_data (q_in)
    );

    // decouples the scanner from output stalls
    kvlt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // one result item per cycle from the head bundle unless the output stalls
    kvlt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // pack result fields, lowest field first
    assign m_tdata = {res.old_indent, res.new_indent, res.token_length,
                      res.token_start, res.kind};
    assign m_tlast = res.final_result;

endmodule

// ----- dv/tb_key_value_line_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// tb_key_value_line_tokenizer_top
// self-checking bench for the key/value line tokenizer
// ----------------------------------------------------------------------------
// Characters are queued up front, then fed one item per handshake by a clocked
// driver. Every accepted character runs through a behavioral tokenizer that
// keeps its own line state and indentation stack. That tokenizer queues the
// events the block should send. A clocked monitor pops them in order and
// compares every field. The stimulus is a short hand-written set of lines,
// then a climb of one space per line until the indentation stack overflows,
// and then random indented key/value lines with noise. Both sides idle at
// random, the receiver stalls once for a long stretch, and the sender once
// waits for the output to drain.
// ----------------------------------------------------------------------------
module tb_key_value_line_tokenizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kvlt_pkg::*;

    localparam int          LEVELS      = STACK_DEPTH_DEF;
    localparam int          MAX_LINE    = LINE_MAX_DEF;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          STALL_AT    = 60;    // items taken when the long stall starts
    localparam int          STALL_LEN   = 400;
    localparam int          CALM_FROM   = 110;   // no idling on either side in this window
    localparam int          CALM_TO     = 190;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       hold;   // wait for all results before offering this item
    } char_item_t;

    typedef struct {
        ev_kind_t    kind;
        logic [9:0]  start;
        logic [10:0] len;
        logic [7:0]  new_ind;
        logic [7:0]  old_ind;
        logic        fin;
    } tok_event_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    char_item_t  char_items[$];
    tok_event_t  expected_events[$];
    tok_event_t  line_events[$];
    logic [7:0]  line_buf[$];
    int unsigned gen_indents[$];

    char_item_t  next_item;
    tok_event_t  got_event;
    int unsigned chars_taken = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;
    bit          stall_done  = 1'b0;
    int unsigned mismatches  = 0;
    bit          calm;

    // behavioral copy of the tokenizer state
    phase_t      kv_phase;
    int unsigned kv_pos;
    int unsigned kv_spaces;
    int unsigned kv_tok_begin;
    int unsigned kv_tok_end;
    bit          kv_val_open;
    logic [7:0]  kv_stack[LEVELS];
    int unsigned kv_levels;

    key_value_line_tokenizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    assign calm = (chars_taken >= CALM_FROM) && (chars_taken < CALM_TO);

    // ------------------------------------------------------------------------
    // tokenizer prediction
    // ------------------------------------------------------------------------
    function automatic bit is_stop(logic [7:0] ch);
        return ch == CH_HASH || ch == CH_CR || ch == CH_LF;
    endfunction

    function automatic void new_line();
        kv_phase     = PH_INDENT;
        kv_pos       = 0;
        kv_spaces    = 0;
        kv_tok_begin = 0;
        kv_tok_end   = 0;
        kv_val_open  = 1'b0;
    endfunction

    function automatic void note_event(ev_kind_t kind, int unsigned start, int unsigned len,
                                       int unsigned old_ind);
        tok_event_t e;
        e.kind    = kind;
        e.start   = start[9:0];
        e.len     = len[10:0];
        e.new_ind = kv_spaces[7:0];
        e.old_ind = old_ind[7:0];
        e.fin     = 1'b0;
        line_events.push_back(e);
    endfunction

    function automatic int unsigned tok_span();
        return (kv_tok_end > kv_tok_begin) ? kv_tok_end - kv_tok_begin : 0;
    endfunction

    // false when the indent cannot be taken (overflow or multi-level dedent)
    function automatic bit check_indent();
        int unsigned top;
        if (kv_levels == 0) begin
            kv_stack[0] = kv_spaces[7:0];
            kv_levels   = 1;
            return 1'b1;
        end
        top = 32'(kv_stack[kv_levels-1]);
        if (top == kv_spaces)
            return 1'b1;
        if (kv_spaces > top) begin
            if (kv_levels >= LEVELS)
                return 1'b0;
            kv_stack[kv_levels] = kv_spaces[7:0];
            kv_levels++;
            note_event(EV_INDENT, 0, 0, top);
            return 1'b1;
        end
        // one level popped, kept even when the dedent is an error
        kv_levels--;
        if (kv_levels > 0 && 32'(kv_stack[kv_levels-1]) > kv_spaces)
            return 1'b0;
        note_event(EV_INDENT, 0, 0, top);
        return 1'b1;
    endfunction

    function automatic void close_line();
        case (kv_phase)
            PH_VALUE: begin
                note_event(EV_VALUE, kv_tok_begin, tok_span(), 0);
                kv_phase = PH_OK;
            end
            PH_INDENT, PH_WS: kv_phase = PH_OK;
            PH_KEY:           kv_phase = PH_ERR;
            default: ;
        endcase
    endfunction

    function automatic void take_char(logic [7:0] ch, int unsigned pos);
        if (kv_phase == PH_INDENT) begin
            if (ch == CH_SPACE) begin
                if (kv_spaces < 255)
                    kv_spaces++;
                return;
            end
            if (!check_indent()) begin
                kv_phase = PH_ERR;
                return;
            end
            kv_tok_begin = pos;
            kv_tok_end   = 0;
            kv_phase     = PH_KEY;
        end
        if (kv_phase == PH_KEY) begin
            if (ch == CH_COLON) begin
                note_event(EV_KEY, kv_tok_begin, tok_span(), 0);
                kv_phase = PH_WS;
            end else if (ch != CH_SPACE) begin
                kv_tok_end = pos + 1;
            end
            return;
        end
        if (kv_phase == PH_WS) begin
            if (ch == CH_SPACE)
                return;
            kv_phase = PH_VALUE;
        end
        if (kv_phase == PH_VALUE) begin
            if (!kv_val_open) begin
                kv_val_open  = 1'b1;
                kv_tok_begin = pos;
                kv_tok_end   = 0;
            end
            if (ch != CH_SPACE)
                kv_tok_end = pos + 1;
        end
    endfunction

    // one accepted character: queue the events it should cause
    task automatic tokenize_char(logic [7:0] ch, logic last);
        int unsigned pos;
        tok_event_t  e;
        pos = kv_pos;
        line_events.delete();
        if (kv_phase < PH_OK) begin
            if (pos >= MAX_LINE) begin
                kv_phase = PH_ERR;
            end else if (is_stop(ch)) begin
                close_line();
            end else begin
                take_char(ch, pos);
                if (last && kv_phase < PH_OK)
                    close_line();
            end
        end
        if (kv_pos < MAX_LINE)
            kv_pos++;
        if (last) begin
            note_event(kv_phase == PH_OK ? EV_LINE_OK : EV_LINE_ERR, 0, 0, 0);
            new_line();
        end
        for (int i = 0; i < line_events.size(); i++) begin
            e     = line_events[i];
            e.fin = (i == line_events.size() - 1);
            expected_events.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------------
    // line builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] plain_char(bit colon_ok);
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(0, 255));
        while (ch == CH_SPACE || is_stop(ch) || (!colon_ok && ch == CH_COLON));
        return ch;
    endfunction

    task automatic add_run(logic [7:0] ch, int unsigned n);
        repeat (n) line_buf.push_back(ch);
    endtask

    task automatic add_string(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // move the built line to the pending items, last flag on its final byte
    task automatic flush_line(bit hold);
        char_item_t it;
        if (line_buf.size() == 0)
            line_buf.push_back(CH_SPACE);
        for (int i = 0; i < line_buf.size(); i++) begin
            it.ch   = line_buf[i];
            it.last = (i == line_buf.size() - 1);
            it.hold = hold && (i == 0);
            char_items.push_back(it);
        end
        line_buf.delete();
    endtask

    // rough shadow of the stack so most indents match, push a level or pop one or more
    function automatic int unsigned pick_indent();
        int unsigned sel;
        int unsigned top;
        int unsigned k;
        top = (gen_indents.size() == 0) ? 0 : gen_indents[$];
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return top;
        if (sel < 65) begin
            top += $urandom_range(1, 4);
            if (gen_indents.size() < LEVELS)
                gen_indents.push_back(top);
            return top;
        end
        if (sel < 90 && gen_indents.size() > 1) begin
            k = $urandom_range(1, gen_indents.size() - 1);
            repeat (k) void'(gen_indents.pop_back());
            return gen_indents[$];
        end
        return $urandom_range(0, 20);
    endfunction

    task automatic add_random_line();
        int unsigned shape;
        int unsigned n;
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
            // raw noise
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_run(CH_SPACE, pick_indent());
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                line_buf.push_back((i > 0 && i < n - 1 && $urandom_range(0, 7) == 0) ?
                                   CH_SPACE : plain_char(1'b0));
            add_run(CH_SPACE, $urandom_range(0, 1));
            // a few lines lose their colon
            if (shape >= 18) begin
                line_buf.push_back(CH_COLON);
                add_run(CH_SPACE, $urandom_range(0, 2));
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++)
                    line_buf.push_back((i > 0 && $urandom_range(0, 5) == 0) ?
                                       CH_SPACE : plain_char(1'b1));
                add_run(CH_SPACE, $urandom_range(0, 2));
            end
            shape = $urandom_range(0, 99);
            if (shape < 15) begin
                line_buf.push_back(CH_HASH);
                repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
            end else if (shape < 30) begin
                line_buf.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        flush_line(1'b0);
    endtask

    task automatic add_random_part(int unsigned n_chars);
        int unsigned goal;
        goal = char_items.size() + n_chars;
        while (char_items.size() < goal)
            add_random_line();
    endtask

    // lines at indent zero, each pops at most one level
    task automatic add_flat_lines(int unsigned n);
        repeat (n) begin
            add_string("a:b");
            flush_line(1'b0);
        end
    endtask

    task automatic add_directed_lines();
        add_string("a:b");          flush_line(1'b0);   // first level, key, value
        add_string("  k : v ");     flush_line(1'b0);   // push, trimmed tokens
        add_string("    b:\n");     flush_line(1'b0);   // push, empty value, line feed
        add_string("c:3");          flush_line(1'b0);   // dedent over two levels
        add_string("x#");           flush_line(1'b0);   // comment inside the key
        add_string(":\r");          flush_line(1'b0);   // empty key, carriage return
        add_string("\n");           flush_line(1'b0);
        add_string(" ");            flush_line(1'b0);   // blank line
        add_string("z:");
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        flush_line(1'b0);
    endtask

    task automatic add_special_lines();
        // climb one space per line until the stack overflows
        for (int i = 1; i <= LEVELS; i++) begin
            add_run(CH_SPACE, i);
            add_string("k");
            flush_line(1'b0);
        end
        add_flat_lines(2);
        // output drains before this line starts
        add_string("a:b");
        flush_line(1'b1);
    endtask

    // ------------------------------------------------------------------------
    // character driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tokenize_char(s_tdata, s_tlast);
                chars_taken <= chars_taken + 1;
            end
            // a held item stays on the bus until it is taken
            if (!s_tvalid || s_tready) begin
                if (char_items.size() == 0 ||
                    (!calm && $urandom_range(0, 99) < 23) ||
                    (char_items[0].hold && expected_events.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    next_item = char_items.pop_front();
                    s_tdata  <= next_item.ch;
                    s_tlast  <= next_item.last;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random idling plus one long stall
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!stall_done && chars_taken >= STALL_AT) begin
            stall_left <= STALL_LEN;
            stall_done <= 1'b1;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 23);
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                $display("%0t ns: result with nothing expected, expected none actual %h/%b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                got_event = expected_events.pop_front();
                check_field("event_kind",   32'(got_event.kind),    32'(m_tdata[2:0]));
                check_field("token_start",  32'(got_event.start),   32'(m_tdata[12:3]));
                check_field("token_length", 32'(got_event.len),     32'(m_tdata[23:13]));
                check_field("new_indent",   32'(got_event.new_ind), 32'(m_tdata[31:24]));
                check_field("old_indent",   32'(got_event.old_ind), 32'(m_tdata[39:32]));
                check_field("final_result", 32'(got_event.fin),     32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_key_value_line_tokenizer_top NOT OK");
            $finish;
        end
    end

    initial begin
        new_line();
        kv_levels = 0;
        for (int i = 0; i < LEVELS; i++)
            kv_stack[i] = '0;

        add_directed_lines();
        add_special_lines();
        gen_indents.push_back(0);
        add_random_part(65);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_items.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_events.size() != 0)
            @(posedge aclk);
        // catch anything the block sends beyond what was expected
        repeat (40) @(posedge aclk);

        if (mismatches == 0)
            $display("tb_key_value_line_tokenizer_top OK");
        else
            $display("tb_key_value_line_tokenizer_top NOT OK");
        $finish;
    end

endmodule
